[sv/clip_rectangle_stack_unit_assert.svh]
// Assertion macros for the clip rectangle stack unit.
// Used by the checker module; has no dependencies of its own.
`ifndef CLIP_RECTANGLE_STACK_UNIT_ASSERT_SVH
`define CLIP_RECTANGLE_STACK_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define CRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CRS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/crs_pkg.sv]
// Shared types and request codes for the clip rectangle stack unit.
// No dependencies; used by every module of the block but crs_ram.
package crs_pkg;

    localparam logic [2:0] REQ_PUSH      = 3'd0;
    localparam logic [2:0] REQ_PUSH_NOCL = 3'd1;
    localparam logic [2:0] REQ_POP       = 3'd2;
    localparam logic [2:0] REQ_VISIBLE   = 3'd3;
    localparam logic [2:0] REQ_CLIP_BOX  = 3'd4;

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } t_state;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic signed [15:0] rect_w;
        logic signed [15:0] rect_h;
    } t_req;

    typedef struct packed {
        logic               clip_active;
        logic signed [15:0] clip_left;
        logic signed [15:0] clip_top;
        logic [14:0]        clip_width;
        logic [14:0]        clip_height;
        logic               visible;
        logic signed [15:0] box_left;
        logic signed [15:0] box_top;
        logic signed [15:0] box_width;
        logic signed [15:0] box_height;
        logic               box_changed;
        logic               push_dropped;
    } t_res;

    // One stack entry as it is kept in memory and in the top cache.
    typedef struct packed {
        logic               active;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] w;
        logic signed [15:0] h;
    } t_entry;

    // Geometry of a box against the top clip.
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] w;
        logic signed [15:0] h;
        logic               visible;
    } t_geom;

endpackage

[sv/crs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module crs_ram #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/crs_geom.sv]
// Box-against-clip geometry: intersection with saturated size, and overlap test.
// Depends on crs_pkg for the request, entry and geometry types.
module crs_geom (
    input  crs_pkg::t_req   i_req,
    input  crs_pkg::t_entry i_clip,
    output crs_pkg::t_geom  o_geom
);

    logic signed [16:0] x_end;
    logic signed [16:0] y_end;
    logic signed [16:0] cx_end;
    logic signed [16:0] cy_end;
    logic signed [16:0] x_in;
    logic signed [16:0] y_in;
    logic signed [16:0] cx_in;
    logic signed [16:0] cy_in;
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic signed [16:0] x2;
    logic signed [16:0] y2;
    logic signed [17:0] dw;
    logic signed [17:0] dh;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    always_comb begin
        x_in   = $signed({i_req.rect_x[15], i_req.rect_x});
        y_in   = $signed({i_req.rect_y[15], i_req.rect_y});
        cx_in  = $signed({i_clip.x[15], i_clip.x});
        cy_in  = $signed({i_clip.y[15], i_clip.y});
        // Right and bottom edges are formed one bit wider so they never wrap.
        x_end  = x_in + $signed({i_req.rect_w[15], i_req.rect_w});
        y_end  = y_in + $signed({i_req.rect_h[15], i_req.rect_h});
        cx_end = cx_in + $signed({i_clip.w[15], i_clip.w});
        cy_end = cy_in + $signed({i_clip.h[15], i_clip.h});

        x1 = (i_req.rect_x > i_clip.x) ? i_req.rect_x : i_clip.x;
        y1 = (i_req.rect_y > i_clip.y) ? i_req.rect_y : i_clip.y;
        x2 = (x_end < cx_end) ? x_end : cx_end;
        y2 = (y_end < cy_end) ? y_end : cy_end;
        dw = $signed({x2[16], x2}) - $signed({x1[15], x1[15], x1});
        dh = $signed({y2[16], y2}) - $signed({y1[15], y1[15], y1});

        o_geom.x = x1;
        o_geom.y = y1;
        o_geom.w = sat16(dw);
        o_geom.h = sat16(dh);
        o_geom.visible = !((x_end <= cx_in) || (x_in >= cx_end) ||
                           (y_end <= cy_in) || (y_in >= cy_end));
    end

endmodule

[sv/clip_rectangle_stack_unit.sv]
// Timing: a result word is strobed in the cycle after its request is accepted; a pop
// that uncovers a lower entry strobes once the entry memory read has returned, holding
// busy for one cycle. All other requests go at one per cycle while busy is low.
// The top entry is cached in registers, so only that pop touches the memory read port.
// Reset (synchronous) empties the stack; the entry memory is not cleared.
module clip_rectangle_stack_unit #(
    parameter int STACK_DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  crs_pkg::t_req i_req,
    output logic          busy,
    output logic          o_strobe,
    output crs_pkg::t_res o_res
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int EW = $bits(crs_pkg::t_entry);

    crs_pkg::t_state r_state;
    crs_pkg::t_state n_state;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    crs_pkg::t_entry r_top;
    crs_pkg::t_entry n_top;
    logic            r_strobe;
    logic            n_strobe;
    crs_pkg::t_res   r_res;
    crs_pkg::t_res   n_res;

    logic            accept;
    logic            top_act;
    logic            full;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    crs_pkg::t_entry wr_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic [EW-1:0]   rd_data;
    crs_pkg::t_entry new_entry;
    crs_pkg::t_geom  geom;

    assign accept  = start && (r_state == crs_pkg::ST_IDLE);
    assign top_act = (r_count != '0) && r_top.active;
    assign full    = (r_count == CW'(STACK_DEPTH));
    assign wr_addr = r_count[AW-1:0];

    crs_geom u_geom (
        .i_req  (i_req),
        .i_clip (r_top),
        .o_geom (geom)
    );

    // Reads and writes never meet on one entry: a read is only issued by a pop,
    // and nothing is accepted until its data has been taken.
    crs_ram #(
        .WIDTH (EW),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            crs_pkg::ST_IDLE: begin
                if (accept && (i_req.req_type == crs_pkg::REQ_POP) &&
                    (r_count > CW'(1))) begin
                    n_state = crs_pkg::ST_POP;
                end
            end
            crs_pkg::ST_POP: begin
                n_state = crs_pkg::ST_IDLE;
            end
            default: begin
                n_state = crs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        busy = (r_state == crs_pkg::ST_POP);
    end

    always_comb begin
        n_count  = r_count;
        n_top    = r_top;
        n_strobe = 1'b0;
        n_res    = '0;
        wr_en    = 1'b0;
        wr_data  = '0;
        rd_en    = 1'b0;
        rd_addr  = AW'(r_count - CW'(2));

        new_entry        = '0;
        new_entry.active = 1'b1;
        if (top_act) begin
            new_entry.x = geom.x;
            new_entry.y = geom.y;
            new_entry.w = geom.w;
            new_entry.h = geom.h;
        end else begin
            new_entry.x = i_req.rect_x;
            new_entry.y = i_req.rect_y;
            new_entry.w = i_req.rect_w;
            new_entry.h = i_req.rect_h;
        end

        case (r_state)
            crs_pkg::ST_IDLE: begin
                if (accept) begin
                    n_strobe = 1'b1;
                    case (i_req.req_type)
                        crs_pkg::REQ_PUSH, crs_pkg::REQ_PUSH_NOCL: begin
                            if (i_req.req_type == crs_pkg::REQ_PUSH_NOCL) begin
                                new_entry = '0;
                            end
                            if (full) begin
                                n_res.push_dropped = 1'b1;
                            end else begin
                                wr_en   = 1'b1;
                                wr_data = new_entry;
                                n_top   = new_entry;
                                n_count = r_count + CW'(1);
                            end
                        end
                        crs_pkg::REQ_POP: begin
                            if (r_count > CW'(1)) begin
                                // The new top comes back from memory next cycle.
                                rd_en    = 1'b1;
                                n_count  = r_count - CW'(1);
                                n_strobe = 1'b0;
                            end else if (r_count == CW'(1)) begin
                                n_count = '0;
                            end
                        end
                        crs_pkg::REQ_VISIBLE: begin
                            n_res.visible = top_act ? geom.visible : 1'b1;
                        end
                        crs_pkg::REQ_CLIP_BOX: begin
                            if (top_act) begin
                                n_res.box_left    = geom.x;
                                n_res.box_top     = geom.y;
                                n_res.box_width   = geom.w;
                                n_res.box_height  = geom.h;
                                n_res.box_changed = (geom.x != i_req.rect_x) ||
                                                    (geom.y != i_req.rect_y) ||
                                                    (geom.w != i_req.rect_w) ||
                                                    (geom.h != i_req.rect_h);
                            end else begin
                                n_res.box_left   = i_req.rect_x;
                                n_res.box_top    = i_req.rect_y;
                                n_res.box_width  = i_req.rect_w;
                                n_res.box_height = i_req.rect_h;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            crs_pkg::ST_POP: begin
                n_top    = crs_pkg::t_entry'(rd_data);
                n_strobe = 1'b1;
            end
            default: begin
            end
        endcase

        // Every result word reports the clip that applies after the request.
        if ((n_count != '0) && n_top.active) begin
            n_res.clip_active = 1'b1;
            n_res.clip_left   = n_top.x;
            n_res.clip_top    = n_top.y;
            n_res.clip_width  = (n_top.w > 16'sd0) ? n_top.w[14:0] : '0;
            n_res.clip_height = (n_top.h > 16'sd0) ? n_top.h[14:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= crs_pkg::ST_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        r_res <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

[sv/crs_chk.sv]
// Port-level checker for the clip rectangle stack unit, bound to the top level.
// Depends on crs_pkg and the assertion macro header.
`include "clip_rectangle_stack_unit_assert.svh"

module crs_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input crs_pkg::t_req i_req,
    input logic          busy,
    input logic          o_strobe,
    input crs_pkg::t_res o_res
);

    // Anything but a pop delivers its word in the very next cycle.
    `CRS_ASSERT_NXT(a_word_follows, i_clk, i_rst_n, start && !busy && (i_req.req_type != crs_pkg::REQ_POP), o_strobe, "accepted request gave no word")

    // The pop wait lasts exactly one cycle and ends with a word.
    `CRS_ASSERT_NXT(a_busy_short, i_clk, i_rst_n, busy, !busy && o_strobe, "pop wait did not end with a word")

    // A word is only ever caused by an acceptance or a pop wait.
    `CRS_ASSERT_IMP(a_no_stray_word, i_clk, i_rst_n, o_strobe, $past(start && !busy) || $past(busy), "word without a request")

    // Without an active clip the clip fields read as zero.
    `CRS_ASSERT_IMP(a_inactive_zero, i_clk, i_rst_n, o_strobe && !o_res.clip_active, (o_res.clip_left == 16'sd0) && (o_res.clip_top == 16'sd0) && (o_res.clip_width == 15'd0) && (o_res.clip_height == 15'd0), "inactive clip with nonzero fields")

endmodule

bind clip_rectangle_stack_unit crs_chk u_crs_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_req    (i_req),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_res    (o_res)
);

[tb/sv/clip_rectangle_stack_unit_test.sv]
// Self-checking testbench for clip_rectangle_stack_unit: directed and random requests,
// checked against a clip stack tracked in the testbench.
// Depends on crs_pkg and the clip_rectangle_stack_unit RTL.
module clip_rectangle_stack_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH = 64;
    localparam int SETTLE_CYCLES = 8;

    // Request codes the block does not define; they only report the clip.
    localparam logic [2:0] REQ_SPARE_LO  = 3'd5;
    localparam logic [2:0] REQ_SPARE_MID = 3'd6;
    localparam logic [2:0] REQ_SPARE_HI  = 3'd7;

    typedef struct packed {
        logic          hold;     // wait until every result is back before offering this word
        crs_pkg::t_req req;
    } t_pending;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start = 1'b0;
    crs_pkg::t_req i_req = '0;
    logic          busy;
    logic          o_strobe;
    crs_pkg::t_res o_res;

    t_pending        pending_reqs[$];
    crs_pkg::t_res   expected_clips[$];
    crs_pkg::t_entry clip_stack[STACK_DEPTH];
    int              clip_depth = 0;
    int              outstanding = 0;
    int              sent_count = 0;
    int              errors = 0;

    clip_rectangle_stack_unit #(
        .STACK_DEPTH(STACK_DEPTH)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_res   (o_res)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int sat16(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Updates the tracked stack for one request and returns the word it must produce.
    function automatic crs_pkg::t_res apply_request(crs_pkg::t_req r);
        crs_pkg::t_res   res;
        crs_pkg::t_entry top;
        int              x, y, w, h, cx, cy, cw, ch, ix, iy, iw, ih;
        logic            top_on;
        res = '0;
        x = int'(r.rect_x);
        y = int'(r.rect_y);
        w = int'(r.rect_w);
        h = int'(r.rect_h);
        top_on = (clip_depth > 0) && clip_stack[clip_depth - 1].active;
        top = top_on ? clip_stack[clip_depth - 1] : '0;
        cx = int'(top.x);
        cy = int'(top.y);
        cw = int'(top.w);
        ch = int'(top.h);
        ix = x;
        iy = y;
        iw = w;
        ih = h;
        if (top_on) begin
            ix = (x > cx) ? x : cx;
            iy = (y > cy) ? y : cy;
            iw = sat16((((x + w) < (cx + cw)) ? (x + w) : (cx + cw)) - ix);
            ih = sat16((((y + h) < (cy + ch)) ? (y + h) : (cy + ch)) - iy);
        end
        case (r.req_type)
            crs_pkg::REQ_PUSH, crs_pkg::REQ_PUSH_NOCL: begin
                if (clip_depth < STACK_DEPTH) begin
                    top = '0;
                    if (r.req_type == crs_pkg::REQ_PUSH) begin
                        top.active = 1'b1;
                        top.x = 16'(ix);
                        top.y = 16'(iy);
                        top.w = 16'(iw);
                        top.h = 16'(ih);
                    end
                    clip_stack[clip_depth] = top;
                    clip_depth++;
                end else begin
                    res.push_dropped = 1'b1;
                end
            end
            crs_pkg::REQ_POP: begin
                if (clip_depth > 0) clip_depth--;
            end
            crs_pkg::REQ_VISIBLE: begin
                res.visible = !(top_on && (x + w <= cx || x >= cx + cw ||
                                           y + h <= cy || y >= cy + ch));
            end
            crs_pkg::REQ_CLIP_BOX: begin
                res.box_left = 16'(ix);
                res.box_top = 16'(iy);
                res.box_width = 16'(iw);
                res.box_height = 16'(ih);
                res.box_changed = (ix != x) || (iy != y) || (iw != w) || (ih != h);
            end
            default: ;
        endcase
        if (clip_depth > 0 && clip_stack[clip_depth - 1].active) begin
            top = clip_stack[clip_depth - 1];
            res.clip_active = 1'b1;
            res.clip_left = top.x;
            res.clip_top = top.y;
            res.clip_width = (top.w > 0) ? top.w[14:0] : 15'd0;
            res.clip_height = (top.h > 0) ? top.h[14:0] : 15'd0;
        end
        return res;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%h, actual 0x%h",
                     $time, name, want, got);
            errors++;
        end
    endtask

    // Driver: a new word goes out once the previous one has been taken.
    always @(posedge i_clk) begin
        t_pending next_req;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (pending_reqs.size() != 0 &&
                !(pending_reqs[0].hold && (outstanding != 0 || start)) &&
                ((sent_count >= 300 && sent_count < 600) || $urandom_range(99) >= 18)) begin
                next_req = pending_reqs.pop_front();
                start <= 1'b1;
                i_req <= next_req.req;
                sent_count++;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: checks each strobed word, then predicts for a word taken at this edge.
    always @(posedge i_clk) begin
        crs_pkg::t_res want;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (expected_clips.size() == 0) begin
                    $display("%0t: unexpected result word, actual %h", $time, o_res);
                    errors++;
                end else begin
                    want = expected_clips.pop_front();
                    check_field("clip_active", 16'(want.clip_active), 16'(o_res.clip_active));
                    check_field("clip_left", want.clip_left, o_res.clip_left);
                    check_field("clip_top", want.clip_top, o_res.clip_top);
                    check_field("clip_width", 16'(want.clip_width), 16'(o_res.clip_width));
                    check_field("clip_height", 16'(want.clip_height), 16'(o_res.clip_height));
                    check_field("visible", 16'(want.visible), 16'(o_res.visible));
                    check_field("box_left", want.box_left, o_res.box_left);
                    check_field("box_top", want.box_top, o_res.box_top);
                    check_field("box_width", want.box_width, o_res.box_width);
                    check_field("box_height", want.box_height, o_res.box_height);
                    check_field("box_changed", 16'(want.box_changed), 16'(o_res.box_changed));
                    check_field("push_dropped", 16'(want.push_dropped),
                                16'(o_res.push_dropped));
                end
            end
            if (start && !busy) expected_clips.push_back(apply_request(i_req));
            outstanding <= expected_clips.size();
        end
    end

    function automatic crs_pkg::t_req make_req(logic [2:0] kind);
        crs_pkg::t_req r;
        r.req_type = kind;
        if ($urandom_range(99) < 70) begin
            // Small boxes near the origin so that clips overlap most of the time.
            r.rect_x = 16'(int'($urandom_range(400)) - 200);
            r.rect_y = 16'(int'($urandom_range(400)) - 200);
            r.rect_w = 16'(int'($urandom_range(330)) - 30);
            r.rect_h = 16'(int'($urandom_range(330)) - 30);
        end else begin
            r.rect_x = 16'($urandom);
            r.rect_y = 16'($urandom);
            r.rect_w = 16'($urandom);
            r.rect_h = 16'($urandom);
        end
        return r;
    endfunction

    task automatic queue_req(logic [2:0] kind, int x, int y, int w, int h);
        t_pending p;
        p.hold = 1'b0;
        p.req.req_type = kind;
        p.req.rect_x = 16'(x);
        p.req.rect_y = 16'(y);
        p.req.rect_w = 16'(w);
        p.req.rect_h = 16'(h);
        pending_reqs.push_back(p);
    endtask

    task automatic queue_random(logic [2:0] kind, logic hold);
        t_pending p;
        p.hold = hold;
        p.req = make_req(kind);
        pending_reqs.push_back(p);
    endtask

    initial begin
        int         push_pct;
        int         pick;
        logic [2:0] kind;

        // Directed: empty stack, unused codes, nesting, inactive entries, saturation.
        queue_req(crs_pkg::REQ_VISIBLE, 0, 0, 1, 1);
        queue_req(crs_pkg::REQ_CLIP_BOX, -32768, -32768, 32767, 32767);
        queue_req(crs_pkg::REQ_POP, 0, 0, 0, 0);
        queue_req(REQ_SPARE_LO, -1, -1, -1, -1);
        queue_req(REQ_SPARE_MID, 32767, -32768, 0, 0);
        queue_req(REQ_SPARE_HI, 0, 0, 0, 0);
        queue_req(crs_pkg::REQ_PUSH, 10, 20, 100, 50);
        queue_req(crs_pkg::REQ_VISIBLE, 50, 40, 10, 10);
        queue_req(crs_pkg::REQ_VISIBLE, 0, 0, 10, 10);
        queue_req(crs_pkg::REQ_CLIP_BOX, 0, 0, 50, 50);
        queue_req(crs_pkg::REQ_CLIP_BOX, 20, 30, 5, 5);
        queue_req(crs_pkg::REQ_PUSH, 50, 40, 200, 200);
        queue_req(crs_pkg::REQ_PUSH_NOCL, 1, 2, 3, 4);
        queue_req(crs_pkg::REQ_VISIBLE, 5000, 5000, 1, 1);
        queue_req(crs_pkg::REQ_CLIP_BOX, -100, -100, 7, 7);
        queue_req(crs_pkg::REQ_POP, 0, 0, 0, 0);
        queue_req(crs_pkg::REQ_POP, 0, 0, 0, 0);
        queue_req(crs_pkg::REQ_POP, 0, 0, 0, 0);
        queue_req(crs_pkg::REQ_PUSH, 32767, 32767, 32767, 32767);
        queue_req(crs_pkg::REQ_CLIP_BOX, -32768, -32768, -32768, -32768);
        queue_req(crs_pkg::REQ_PUSH, 0, 0, -5, -5);
        queue_req(crs_pkg::REQ_VISIBLE, 32767, 32767, 1, 1);
        queue_req(crs_pkg::REQ_POP, 0, 0, 0, 0);
        queue_req(crs_pkg::REQ_POP, 0, 0, 0, 0);

        // Random: a random walk of the stack depth, with two passes that fill it past full.
        push_pct = 30;
        for (int i = 0; i < 1150; i++) begin
            if (i % 100 == 0) push_pct = int'($urandom_range(40, 15));
            if (i == 200 || i == 800) begin
                for (int j = 0; j < 75; j++) begin
                    pick = int'($urandom_range(9));
                    kind = (pick < 6) ? crs_pkg::REQ_PUSH :
                           (pick < 8) ? crs_pkg::REQ_PUSH_NOCL :
                           (pick == 8) ? crs_pkg::REQ_VISIBLE : crs_pkg::REQ_CLIP_BOX;
                    queue_random(kind, 1'b0);
                end
            end
            pick = int'($urandom_range(99));
            if (pick < 4)
                kind = 3'($urandom_range(int'(REQ_SPARE_HI), int'(REQ_SPARE_LO)));
            else if (pick < 4 + push_pct)
                kind = ($urandom_range(4) == 0) ? crs_pkg::REQ_PUSH_NOCL : crs_pkg::REQ_PUSH;
            else if (pick < 26 + push_pct) kind = crs_pkg::REQ_POP;
            else if (pick < 26 + push_pct + (74 - push_pct) / 2) kind = crs_pkg::REQ_VISIBLE;
            else kind = crs_pkg::REQ_CLIP_BOX;
            queue_random(kind, (i % 400) == 0);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || start || outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_clips.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #200000;
        $display("%0t: timeout", $time);
        $display("TEST FAILED");
        $finish;
    end

endmodule

[clip_rectangle_stack_unit.f]
+incdir+sv
sv/crs_pkg.sv
sv/crs_ram.sv
sv/crs_geom.sv
sv/clip_rectangle_stack_unit.sv
sv/crs_chk.sv
tb/sv/clip_rectangle_stack_unit_test.sv
